[src/triangle_face_normal_top_defines.svh]
// assertion macros for the triangle face normal block
`ifndef TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH

// consequence holds in the same cycle as the condition
`define TFN_ASSERT_NOW(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("tfn assertion failed");

// consequence holds in the next cycle after the condition
`define TFN_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("tfn assertion failed");

`endif

[src/tfn_pkg.sv]
// constants for the triangle face normal block
package tfn_pkg;
    localparam int KEEP_BITS  = 30;
    localparam int SQ_W       = 2 * KEEP_BITS + 2;
    localparam int ROOT_STEPS = SQ_W / 2;
    localparam int ROOT_W     = KEEP_BITS + 1;
    localparam int OUT_W      = 16;
    localparam int OUT_MAX    = 32767;
endpackage

[src/triangle_face_normal_top.sv]
// triangle face normal: unit normal of a face from three vertices, fully pipelined
//
// Takes one face word per cycle unless stalled and returns one normal word per face, in order.
// The edges v1-v2 and v1-v3 are crossed exactly, the cross product is scaled
// down to 30 significant bits when larger, its length is found by a
// restoring square root with one result bit per stage, and each component is
// divided by that length with one quotient bit per stage (rounded half up,
// NORMAL_FRAC fraction bits, saturated to 32767). A face whose cross product
// is zero gives a zero normal with degenerate set. The pipeline has seven
// front stages, 31 square root stages, one divider set-up stage,
// NORMAL_FRAC + 1 divider stages and the output register. The whole
// pipeline advances together; it holds only while a result word sits in the
// output register and normal_stall is high, so throughput is one face per
// cycle whenever the consumer takes words.
`include "triangle_face_normal_top_defines.svh"

module triangle_face_normal_top
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int NORMAL_FRAC = 14
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          face_valid,
    output logic                          face_stall,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_z,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_z,
    input  logic signed [COORD_WIDTH-1:0] third_x,
    input  logic signed [COORD_WIDTH-1:0] third_y,
    input  logic signed [COORD_WIDTH-1:0] third_z,
    output logic                          normal_valid,
    input  logic                          normal_stall,
    output logic signed [OUT_W-1:0]       normal_x,
    output logic signed [OUT_W-1:0]       normal_y,
    output logic signed [OUT_W-1:0]       normal_z,
    output logic                          degenerate
);

    // edge, product and magnitude widths
    localparam int EDGE_W    = COORD_WIDTH + 1;
    localparam int PROD_W    = 2 * EDGE_W;
    localparam int MAG_W     = 2 * COORD_WIDTH + 2;
    localparam int CROSS_W   = MAG_W + 1;
    localparam int BL_W      = $clog2(MAG_W + 1);
    localparam int Q_W       = NORMAL_FRAC + 1;
    localparam int NUM_W     = KEEP_BITS + NORMAL_FRAC + 1;
    localparam int CMP_W     = ROOT_W + NORMAL_FRAC + 1;
    localparam int DIV_STEPS = NORMAL_FRAC + 1;

    // global advance: everything moves unless a held result is stalled
    logic en;
    assign en         = !(normal_valid && normal_stall);
    assign face_stall = !en;

    // stage 1: edges
    logic                     s1_v_reg;
    logic signed [EDGE_W-1:0] e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;

    // stage 2: six partial products
    logic                     s2_v_reg;
    logic signed [PROD_W-1:0] p_reg [0:5];

    // stage 3: cross product as sign and magnitude
    logic                     s3_v_reg;
    logic [2:0][MAG_W-1:0]    mag3_reg;
    logic [2:0]               neg3_reg;

    // stage 4: shift amount
    logic                     s4_v_reg;
    logic [2:0][MAG_W-1:0]    mag4_reg;
    logic [2:0]               neg4_reg;
    logic                     deg4_reg;
    logic [BL_W-1:0]          shift4_reg;

    // stage 5: scaled magnitudes
    logic                     s5_v_reg;
    logic [2:0][KEEP_BITS-1:0] a5_reg;
    logic [2:0]               neg5_reg;
    logic                     deg5_reg;

    // stage 6: squares
    logic                     s6_v_reg;
    logic [2:0][KEEP_BITS-1:0] a6_reg;
    logic [2:0][2*KEEP_BITS-1:0] sq6_reg;
    logic [2:0]               neg6_reg;
    logic                     deg6_reg;

    // square root pipeline, index 0 holds the sum of squares
    logic                      rt_v_reg   [0:ROOT_STEPS];
    logic [SQ_W-1:0]           rt_x_reg   [0:ROOT_STEPS];
    logic [SQ_W-1:0]           rt_r_reg   [0:ROOT_STEPS];
    logic [2:0][KEEP_BITS-1:0] rt_a_reg   [0:ROOT_STEPS];
    logic [2:0]                rt_neg_reg [0:ROOT_STEPS];
    logic                      rt_deg_reg [0:ROOT_STEPS];

    // divider pipeline, index 0 holds the rounded numerators
    logic                      dv_v_reg   [0:DIV_STEPS];
    logic [ROOT_W-1:0]         dv_l_reg   [0:DIV_STEPS];
    logic [2:0][NUM_W-1:0]     dv_rem_reg [0:DIV_STEPS];
    logic [2:0][Q_W-1:0]       dv_q_reg   [0:DIV_STEPS];
    logic [2:0]                dv_neg_reg [0:DIV_STEPS];
    logic                      dv_deg_reg [0:DIV_STEPS];

    // output word
    logic                      out_v_reg;
    logic [2:0][OUT_W-1:0]     out_n_reg;
    logic                      out_deg_reg;

    // ---------------- front stages ----------------
    logic signed [CROSS_W-1:0] cross_next [0:2];
    logic [2:0][MAG_W-1:0]     mag3_next;
    logic [2:0]                neg3_next;
    logic [MAG_W-1:0]          mag_or;
    logic [BL_W-1:0]           bitlen;
    logic [BL_W-1:0]           shift4_next;
    logic [2:0][KEEP_BITS-1:0] a5_next;
    logic [SQ_W-1:0]           sum_next;

    always_comb
    begin
        cross_next[0] = CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
        cross_next[1] = CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
        cross_next[2] = CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            neg3_next[i] = cross_next[i][CROSS_W-1];
            mag3_next[i] = neg3_next[i] ? MAG_W'(-cross_next[i]) : MAG_W'(cross_next[i]);
        end
    end

    // bit length of the largest magnitude equals that of their or
    always_comb
    begin
        mag_or = mag3_reg[0] | mag3_reg[1] | mag3_reg[2];
        bitlen = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag_or[i])
            begin
                bitlen = BL_W'(i + 1);
            end
        end
        shift4_next = (int'(bitlen) > KEEP_BITS) ? BL_W'(int'(bitlen) - KEEP_BITS) : '0;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a5_next[i] = KEEP_BITS'(mag4_reg[i] >> shift4_reg);
        end
        sum_next = SQ_W'(sq6_reg[0]) + SQ_W'(sq6_reg[1]) + SQ_W'(sq6_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            s4_v_reg    <= 1'b0;
            s5_v_reg    <= 1'b0;
            s6_v_reg    <= 1'b0;
            rt_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= face_valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            s6_v_reg    <= s5_v_reg;
            rt_v_reg[0] <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1x_reg <= EDGE_W'(first_x) - EDGE_W'(second_x);
            e1y_reg <= EDGE_W'(first_y) - EDGE_W'(second_y);
            e1z_reg <= EDGE_W'(first_z) - EDGE_W'(second_z);
            e2x_reg <= EDGE_W'(first_x) - EDGE_W'(third_x);
            e2y_reg <= EDGE_W'(first_y) - EDGE_W'(third_y);
            e2z_reg <= EDGE_W'(first_z) - EDGE_W'(third_z);

            p_reg[0] <= PROD_W'(e1y_reg) * PROD_W'(e2z_reg);
            p_reg[1] <= PROD_W'(e1z_reg) * PROD_W'(e2y_reg);
            p_reg[2] <= PROD_W'(e1z_reg) * PROD_W'(e2x_reg);
            p_reg[3] <= PROD_W'(e1x_reg) * PROD_W'(e2z_reg);
            p_reg[4] <= PROD_W'(e1x_reg) * PROD_W'(e2y_reg);
            p_reg[5] <= PROD_W'(e1y_reg) * PROD_W'(e2x_reg);

            mag3_reg <= mag3_next;
            neg3_reg <= neg3_next;

            mag4_reg   <= mag3_reg;
            neg4_reg   <= neg3_reg;
            deg4_reg   <= (mag_or == '0);
            shift4_reg <= shift4_next;

            a5_reg   <= a5_next;
            neg5_reg <= neg4_reg;
            deg5_reg <= deg4_reg;

            a6_reg   <= a5_reg;
            neg6_reg <= neg5_reg;
            deg6_reg <= deg5_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq6_reg[i] <= (2*KEEP_BITS)'(a5_reg[i]) * (2*KEEP_BITS)'(a5_reg[i]);
            end

            rt_x_reg[0]   <= sum_next;
            rt_r_reg[0]   <= '0;
            rt_a_reg[0]   <= a6_reg;
            rt_neg_reg[0] <= neg6_reg;
            rt_deg_reg[0] <= deg6_reg;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_root
        localparam logic [SQ_W:0] STEP_BIT = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W:0]   trial;
        logic            take;
        logic [SQ_W-1:0] x_next;
        logic [SQ_W-1:0] r_next;

        always_comb
        begin
            trial  = {1'b0, rt_r_reg[k]} + STEP_BIT;
            take   = ({1'b0, rt_x_reg[k]} >= trial);
            x_next = take ? rt_x_reg[k] - trial[SQ_W-1:0] : rt_x_reg[k];
            r_next = take ? (rt_r_reg[k] >> 1) + STEP_BIT[SQ_W-1:0] : (rt_r_reg[k] >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                rt_v_reg[k+1] <= rt_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_x_reg[k+1]   <= x_next;
                rt_r_reg[k+1]   <= r_next;
                rt_a_reg[k+1]   <= rt_a_reg[k];
                rt_neg_reg[k+1] <= rt_neg_reg[k];
                rt_deg_reg[k+1] <= rt_deg_reg[k];
            end
        end
    end

    // ---------------- divider set-up: a * 2^frac + length / 2 ----------------
    logic [ROOT_W-1:0]     len_next;
    logic [2:0][NUM_W-1:0] num_next;

    always_comb
    begin
        len_next = ROOT_W'(rt_r_reg[ROOT_STEPS]);
        for (int i = 0; i < 3; i++)
        begin
            num_next[i] = (NUM_W'(rt_a_reg[ROOT_STEPS][i]) << NORMAL_FRAC)
                        + NUM_W'(len_next >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= rt_v_reg[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_l_reg[0]   <= len_next;
            dv_rem_reg[0] <= num_next;
            dv_q_reg[0]   <= '0;
            dv_neg_reg[0] <= rt_neg_reg[ROOT_STEPS];
            dv_deg_reg[0] <= rt_deg_reg[ROOT_STEPS];
        end
    end

    // ---------------- divider, one quotient bit per stage, msb first ----------------
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [CMP_W-1:0]      dsh;
        logic [2:0]            take;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][Q_W-1:0]   q_next;

        always_comb
        begin
            dsh = CMP_W'(dv_l_reg[j]) << (NORMAL_FRAC - j);
            for (int i = 0; i < 3; i++)
            begin
                take[i]     = (CMP_W'(dv_rem_reg[j][i]) >= dsh);
                rem_next[i] = take[i] ? NUM_W'(CMP_W'(dv_rem_reg[j][i]) - dsh)
                                      : dv_rem_reg[j][i];
                q_next[i]   = {dv_q_reg[j][i][Q_W-2:0], take[i]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_l_reg[j+1]   <= dv_l_reg[j];
                dv_rem_reg[j+1] <= rem_next;
                dv_q_reg[j+1]   <= q_next;
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_deg_reg[j+1] <= dv_deg_reg[j];
            end
        end
    end

    // ---------------- saturate, apply sign, output register ----------------
    logic [2:0][OUT_W-1:0] mag_out;
    logic [2:0][OUT_W-1:0] out_n_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_out[i]    = (dv_q_reg[DIV_STEPS][i] > OUT_MAX) ? OUT_W'(OUT_MAX)
                                                               : OUT_W'(dv_q_reg[DIV_STEPS][i]);
            out_n_next[i] = dv_deg_reg[DIV_STEPS] ? '0
                          : (dv_neg_reg[DIV_STEPS][i] ? -mag_out[i] : mag_out[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= dv_v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_n_reg   <= out_n_next;
            out_deg_reg <= dv_deg_reg[DIV_STEPS];
        end
    end

    assign normal_valid = out_v_reg;
    assign normal_x     = out_n_reg[0];
    assign normal_y     = out_n_reg[1];
    assign normal_z     = out_n_reg[2];
    assign degenerate   = out_deg_reg;

    // ---------------- assertions ----------------
    `TFN_ASSERT_NOW(a_degen_zero, normal_valid && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0)
    `TFN_ASSERT_NOW(a_len_nonzero, dv_v_reg[0] && !dv_deg_reg[0], dv_l_reg[0] != 0)
    `TFN_ASSERT_NEXT(a_freeze, normal_valid && normal_stall, $stable(rt_x_reg[0]) && $stable(out_n_reg))

endmodule

[tb/sv/triangle_face_normal_top_tb.sv]
// testbench for the triangle face normal block: random and directed faces checked against a predictor
`timescale 1ns / 100ps

module triangle_face_normal_top_tb;
    import tfn_pkg::*;

    localparam int CW = 16;
    localparam int NF = 14;
    // pipeline depth plus margin
    localparam int DRAIN_CYCLES = NF + 41 + 20;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    degen;
    } normal_word_t;

    logic clk;
    logic rst_n;
    logic face_valid;
    logic face_stall;
    logic signed [CW-1:0] first_x, first_y, first_z;
    logic signed [CW-1:0] second_x, second_y, second_z;
    logic signed [CW-1:0] third_x, third_y, third_z;
    logic normal_valid;
    logic normal_stall;
    logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;
    logic degenerate;

    normal_word_t pending_normals[$];
    int faces_sent;
    int normals_seen;
    int degen_seen;
    int mismatch_count;
    // idling percentages for the current phase
    int send_idle_pct;
    int recv_stall_pct;

    triangle_face_normal_top #(
        .COORD_WIDTH(CW),
        .NORMAL_FRAC(NF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .face_valid(face_valid),
        .face_stall(face_stall),
        .first_x(first_x),
        .first_y(first_y),
        .first_z(first_z),
        .second_x(second_x),
        .second_y(second_y),
        .second_z(second_z),
        .third_x(third_x),
        .third_y(third_y),
        .third_z(third_z),
        .normal_valid(normal_valid),
        .normal_stall(normal_stall),
        .normal_x(normal_x),
        .normal_y(normal_y),
        .normal_z(normal_z),
        .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // integer square root, one result bit per step
    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // expected unit normal of the face v1, v2, v3
    function automatic normal_word_t face_normal(
        logic signed [CW-1:0] ax, logic signed [CW-1:0] ay, logic signed [CW-1:0] az,
        logic signed [CW-1:0] bx, logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
        logic signed [CW-1:0] cx, logic signed [CW-1:0] cy, logic signed [CW-1:0] cz);
        longint e1[3];
        longint e2[3];
        longint cr[3];
        longint unsigned mag[3];
        longint unsigned peak;
        longint unsigned sumsq;
        longint unsigned len;
        longint unsigned q;
        int nbits;
        int sh;
        logic signed [OUT_W-1:0] comp[3];
        normal_word_t w;
        e1[0] = longint'(ax) - longint'(bx);
        e1[1] = longint'(ay) - longint'(by);
        e1[2] = longint'(az) - longint'(bz);
        e2[0] = longint'(ax) - longint'(cx);
        e2[1] = longint'(ay) - longint'(cy);
        e2[2] = longint'(az) - longint'(cz);
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        peak = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
            if (mag[i] > peak)
                peak = mag[i];
        end
        if (peak == 0)
        begin
            w.nx = '0;
            w.ny = '0;
            w.nz = '0;
            w.degen = 1'b1;
            return w;
        end
        nbits = 0;
        while ((peak >> nbits) != 0)
            nbits++;
        sh = (nbits > KEEP_BITS) ? nbits - KEEP_BITS : 0;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> sh;
            sumsq += mag[i] * mag[i];
        end
        len = root_floor(sumsq);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << NF) + (len >> 1)) / len;
            if (q > OUT_MAX)
                q = OUT_MAX;
            comp[i] = (cr[i] < 0) ? -OUT_W'(q) : OUT_W'(q);
        end
        w.nx = comp[0];
        w.ny = comp[1];
        w.nz = comp[2];
        w.degen = 1'b0;
        return w;
    endfunction

    // drive one face and hold it until taken; valid stays up for a following word
    task automatic send_face(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
        logic signed [CW-1:0] az, logic signed [CW-1:0] bx, logic signed [CW-1:0] by,
        logic signed [CW-1:0] bz, logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
        logic signed [CW-1:0] cz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            face_valid <= 1'b0;
            @(posedge clk);
        end
        face_valid <= 1'b1;
        first_x <= ax;
        first_y <= ay;
        first_z <= az;
        second_x <= bx;
        second_y <= by;
        second_z <= bz;
        third_x <= cx;
        third_y <= cy;
        third_z <= cz;
        @(posedge clk);
        while (face_stall)
            @(posedge clk);
        // the word was taken at this edge, so queue its expectation now
        pending_normals = {pending_normals,
                           face_normal(ax, ay, az, bx, by, bz, cx, cy, cz)};
        faces_sent++;
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return CW'($urandom_range(15)) - CW'(8);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic send_random_face();
        logic signed [CW-1:0] p[9];
        foreach (p[i])
            p[i] = rand_coord();
        // sometimes make the face collinear or repeat a vertex
        case ($urandom_range(9))
            0:
            begin
                p[3] = p[0];
                p[4] = p[1];
                p[5] = p[2];
            end
            1:
            begin
                p[6] = p[3];
                p[7] = p[4];
                p[8] = p[5];
            end
            2:
            begin
                // third vertex at 2*v2 - v1, on the same line
                p[0] = CW'($urandom_range(2000)) - CW'(1000);
                p[1] = CW'($urandom_range(2000)) - CW'(1000);
                p[2] = CW'($urandom_range(2000)) - CW'(1000);
                p[3] = CW'($urandom_range(2000)) - CW'(1000);
                p[4] = CW'($urandom_range(2000)) - CW'(1000);
                p[5] = CW'($urandom_range(2000)) - CW'(1000);
                p[6] = CW'(2 * p[3] - p[0]);
                p[7] = CW'(2 * p[4] - p[1]);
                p[8] = CW'(2 * p[5] - p[2]);
            end
            default: ;
        endcase
        send_face(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]);
    endtask

    // drop valid and wait until every expected word has come back
    task automatic wait_drained();
        face_valid <= 1'b0;
        while (pending_normals.size() != 0)
            @(posedge clk);
    endtask

    // extremes, axis-aligned faces, both orientations, degenerate faces
    task automatic test_directed();
        send_face(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_face(0, 0, 0, 0, 1, 0, 1, 0, 0);
        send_face(0, 0, 0, 0, 0, 1, 1, 0, 0);
        send_face(0, 0, 0, 0, 1, 0, 0, 0, 1);
        send_face(5, 5, 5, 5, 5, 5, 5, 5, 5);
        send_face(0, 0, 0, 1, 1, 1, 2, 2, 2);
        send_face(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh7fff, 16'sh8000);
        send_face(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh8000, 16'sh8000);
        send_face(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                  16'sh8000, 16'sh8000, 16'sh7fff);
        send_face(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh7fff, 16'sh7fff, 16'sh8000);
        send_face(-1, -1, -1, 0, 0, 0, 1, -1, 0);
        send_face(16'shffff, 16'sh5555, 16'shaaaa, 16'sh0000, 16'shaaaa, 16'sh5555,
                  16'sh5555, 16'sh0000, 16'shffff);
        send_face(1, 2, 3, 4, 5, 6, 7, 8, 10);
        send_face(16'sh8000, 0, 0, 16'sh7fff, 0, 0, 0, 0, 0);
        send_face(3, 0, 0, 0, 4, 0, 0, 0, 0);
    endtask

    task automatic test_random_phase(int n, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n)
            send_random_face();
    endtask

    // sender holds off until the pipeline has emptied, then bursts again
    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_stall_pct = 30;
        repeat (10)
            send_random_face();
        wait_drained();
        repeat (10)
            send_random_face();
    endtask

    // random receiver stall, redrawn every cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            normal_stall <= 1'b0;
        else
            normal_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare every taken normal word with the oldest expectation
    always @(posedge clk)
    begin
        normal_word_t want;
        if (rst_n && normal_valid && !normal_stall)
        begin
            normals_seen++;
            if (degenerate)
                degen_seen++;
            if (pending_normals.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected normal word %0d %0d %0d deg %0b",
                             normal_x, normal_y, normal_z, degenerate);
            end
            else
            begin
                want = pending_normals.pop_front();
                if (normal_x !== want.nx || normal_y !== want.ny ||
                    normal_z !== want.nz || degenerate !== want.degen)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("normal word %0d: want %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                                 normals_seen, want.nx, want.ny, want.nz, want.degen,
                                 normal_x, normal_y, normal_z, degenerate);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        face_valid = 1'b0;
        first_x = '0;
        first_y = '0;
        first_z = '0;
        second_x = '0;
        second_y = '0;
        second_z = '0;
        third_x = '0;
        third_y = '0;
        third_z = '0;
        faces_sent = 0;
        normals_seen = 0;
        degen_seen = 0;
        mismatch_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(500, 0, 0);
        test_random_phase(300, 75, 0);
        test_random_phase(300, 0, 75);
        test_random_phase(300, 6, 6);
        test_drain_pause();

        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("faces sent %0d, normals checked %0d, degenerate %0d",
                 faces_sent, normals_seen, degen_seen);
        $display("idling phases covered: none, sender 75%%, receiver 75%%, both 6%%, full drain");
        if (mismatch_count == 0 && pending_normals.size() == 0)
            $display("triangle_face_normal_top: match");
        else
            $display("triangle_face_normal_top: mismatch");
        $finish;
    end

    // run limit, well above the slowest correct run
    initial
    begin
        #2000000;
        $display("triangle_face_normal_top: mismatch");
        $finish;
    end

endmodule
